>>> src/bso_pkg.sv
package bso_pkg;

    localparam int MAX_RANK   = 8;
    localparam int MIN_RANK   = 3;
    localparam int COEF_DEPTH = 64;

    localparam int ADDR_W = $clog2(COEF_DEPTH);
    localparam int IDX_W  = $clog2(MAX_RANK);
    localparam int RANK_W = 4;
    localparam int CNT_W  = 7;
    localparam int SQ_W   = 2 * RANK_W;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 3;

    // unsigned Q30 values in [0, 1.0]
    localparam int            Q_W    = 31;
    localparam int            Q_FRAC = 30;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_FRAC;

    localparam int ACC_W = 68;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_WINDOW = 2'd1;
    localparam logic [1:0] STAT_RANK   = 2'd2;

    localparam logic [CFG_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_W-1:0] CFG_MAX_X = 3'd1;
    localparam logic [CFG_W-1:0] CFG_MIN_Y = 3'd2;
    localparam logic [CFG_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [CFG_W-1:0] CFG_RANK  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_COUNT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POW,
        ST_BASIS,
        ST_MAC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic            done;
        logic [Q_W-1:0] quot;
    } t_div_res;

endpackage

>>> src/bso_div.sv
module bso_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bso_pkg::DATA_W-1:0]      i_num,
    input  logic [bso_pkg::DATA_W-1:0]      i_den,
    output bso_pkg::t_div_res               o_res
);

    // restoring divider, one quotient bit per cycle: floor(num * 2^30 / den), num <= den
    logic                          r_busy;
    logic                          r_done;
    logic [4:0]                    r_cnt;
    logic [bso_pkg::DATA_W:0]      r_rem;
    logic [bso_pkg::DATA_W-1:0]    r_den;
    logic [bso_pkg::Q_W-1:0]       r_quot;
    logic [bso_pkg::DATA_W:0]      sh;
    logic                          bit_q;

    always_comb begin
        sh    = {r_rem[bso_pkg::DATA_W-1:0], 1'b0};
        bit_q = (sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= (i_num != i_den);
            r_done <= (i_num == i_den);
        end else if (r_busy && r_cnt == 5'(bso_pkg::Q_FRAC - 1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= {1'b0, i_num};
            r_cnt  <= '0;
            r_quot <= (i_num == i_den) ? bso_pkg::Q_ONE : '0;
        end else if (r_busy) begin
            r_rem  <= bit_q ? (sh - {1'b0, r_den}) : sh;
            r_quot <= {r_quot[bso_pkg::Q_W-2:0], bit_q};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

>>> src/bezier_surface_offset_eval.sv
// bezier surface offset evaluator: table-position correction
//
// input channel (i_valid / o_stall) takes words of two kinds. a load word
// (i_req_type 0) writes one X and one Y Q16.16 coefficient into the two
// coefficient memories and gives no result. an evaluate word
// (i_req_type 1) checks the position against the calibration window and the
// rank against the loaded count, then gives one result word on the output
// channel (o_valid / i_stall): offsets and status, offsets zero on error.
// an evaluate that passes its checks runs through the serial dividers that
// normalize u and v, the power and basis steps (each basis term a product,
// then its binomial weight) and the coefficient loop, which reads one memory
// entry per cycle through a three-stage multiply-accumulate pipe.
// one word is in work at a time;
// o_stall is high while an evaluate is in work.
// the result sits in an output register, so new words are taken while a
// result waits on a stalled receiver; a finished evaluate holds in its last
// step until the output register frees.
// synchronous active-low reset returns the window registers to (0, 1.0],
// rank to 3 and count to 0; memory contents stay undefined until loaded.
// configuration writes take effect at once; the user must make them only while idle, the block does not enforce it.
module bezier_surface_offset_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bso_pkg::CFG_W-1:0]           i_cfg_idx,
    input  logic [bso_pkg::DATA_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [bso_pkg::ADDR_W-1:0]          i_coef_index,
    input  logic signed [bso_pkg::DATA_W-1:0]   i_coef_x_val,
    input  logic signed [bso_pkg::DATA_W-1:0]   i_coef_y_val,
    input  logic signed [bso_pkg::DATA_W-1:0]   i_pos_x,
    input  logic signed [bso_pkg::DATA_W-1:0]   i_pos_y,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bso_pkg::DATA_W-1:0]   o_offset_x,
    output logic signed [bso_pkg::DATA_W-1:0]   o_offset_y,
    output logic [1:0]                          o_status
);

    localparam int QW = bso_pkg::Q_W;
    localparam int DW = bso_pkg::DATA_W;
    localparam int IW = bso_pkg::IDX_W;
    localparam int AW = bso_pkg::ADDR_W;
    localparam int PW = 2 * DW;

    // pascal rows for degrees 0 to 7
    localparam logic [5:0] BINOM [bso_pkg::MAX_RANK][bso_pkg::MAX_RANK] = '{
        '{6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2,  6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3,  6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4,  6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5,  6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6,  6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7,  6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    // configuration registers
    logic signed [DW-1:0]               r_min_x, r_max_x, r_min_y, r_max_y;
    logic [bso_pkg::RANK_W-1:0]         r_rank;
    logic [bso_pkg::CNT_W-1:0]          r_count;

    bso_pkg::t_state                    r_state, n_state;

    // coefficient memories and their registered read data
    logic signed [DW-1:0]               mem_x [bso_pkg::COEF_DEPTH];
    logic signed [DW-1:0]               mem_y [bso_pkg::COEF_DEPTH];
    logic signed [DW-1:0]               r_rd_x, r_rd_y;

    // power, basis and accumulate storage
    logic [QW-1:0]                      r_pu_x [bso_pkg::MAX_RANK];
    logic [QW-1:0]                      r_pu_y [bso_pkg::MAX_RANK];
    logic [QW-1:0]                      r_pq_x [bso_pkg::MAX_RANK];   // stored reversed
    logic [QW-1:0]                      r_pq_y [bso_pkg::MAX_RANK];
    logic [QW-1:0]                      r_bx [bso_pkg::MAX_RANK];
    logic [QW-1:0]                      r_by [bso_pkg::MAX_RANK];
    logic [QW-1:0]                      r_lu_x, r_lq_x, r_lu_y, r_lq_y;
    logic [QW-1:0]                      r_bp_x, r_bp_y;
    logic [QW-1:0]                      r_w;
    logic signed [PW-1:0]               r_px_x, r_px_y;
    logic signed [bso_pkg::ACC_W-1:0]   r_acc_x, r_acc_y;

    logic [IW-1:0]                      r_k, r_i, r_j;
    logic [AW-1:0]                      r_s;
    logic                               r_ph, r_iss, r_v1, r_v2;
    logic [1:0]                         r_status;
    logic [DW-1:0]                      r_num_x, r_den_x, r_num_y, r_den_y;

    logic                               r_o_valid;
    logic signed [DW-1:0]               r_o_x, r_o_y;
    logic [1:0]                         r_o_status;

    // control
    logic                               in_acc, eval_acc, load_acc, out_free;
    logic                               win_bad, rank_bad;
    logic [1:0]                         chk_status;
    logic [bso_pkg::SQ_W-1:0]           rank_sq;
    logic [IW-1:0]                      deg;
    logic                               div_go, pow_last, basis_last, mac_done;
    logic [DW:0]                        diff_x, diff_y, span_x, span_y;
    logic [QW-1:0]                      q_x, q_y;
    logic [PW-1:0]                      m_pu_x, m_pq_x, m_pu_y, m_pq_y;
    logic [PW-1:0]                      m_b_x, m_b_y, m_w;
    bso_pkg::t_div_res                  div_x, div_y;

    assign in_acc   = i_valid && !o_stall;
    assign eval_acc = in_acc && i_req_type;
    assign load_acc = in_acc && !i_req_type;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != bso_pkg::ST_IDLE);

    assign rank_sq = bso_pkg::SQ_W'(r_rank) * bso_pkg::SQ_W'(r_rank);
    assign deg     = IW'(r_rank - bso_pkg::RANK_W'(1));

    // window is (min, max]; an empty window rejects everything
    always_comb begin
        win_bad  = (i_pos_x <= r_min_x) || (i_pos_x > r_max_x) ||
                   (i_pos_y <= r_min_y) || (i_pos_y > r_max_y);
        rank_bad = (r_rank < bso_pkg::RANK_W'(bso_pkg::MIN_RANK)) ||
                   ({1'b0, r_rank} > 5'(bso_pkg::MAX_RANK)) ||
                   ({1'b0, rank_sq} > 9'(bso_pkg::COEF_DEPTH)) ||
                   ({1'b0, r_count} != rank_sq);
        if (win_bad) begin
            chk_status = bso_pkg::STAT_WINDOW;
        end else if (rank_bad) begin
            chk_status = bso_pkg::STAT_RANK;
        end else begin
            chk_status = bso_pkg::STAT_OK;
        end
        diff_x = {i_pos_x[DW-1], i_pos_x} - {r_min_x[DW-1], r_min_x};
        diff_y = {i_pos_y[DW-1], i_pos_y} - {r_min_y[DW-1], r_min_y};
        span_x = {r_max_x[DW-1], r_max_x} - {r_min_x[DW-1], r_min_x};
        span_y = {r_max_y[DW-1], r_max_y} - {r_min_y[DW-1], r_min_y};
    end

    assign div_go = eval_acc && (chk_status == bso_pkg::STAT_OK);

    bso_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (diff_x[DW-1:0]),
        .i_den   (span_x[DW-1:0]),
        .o_res   (div_x)
    );

    bso_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (diff_y[DW-1:0]),
        .i_den   (span_y[DW-1:0]),
        .o_res   (div_y)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= DW'(65536);
            r_min_y <= '0;
            r_max_y <= DW'(65536);
            r_rank  <= bso_pkg::RANK_W'(3);
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bso_pkg::CFG_MIN_X: r_min_x <= i_cfg_data;
                bso_pkg::CFG_MAX_X: r_max_x <= i_cfg_data;
                bso_pkg::CFG_MIN_Y: r_min_y <= i_cfg_data;
                bso_pkg::CFG_MAX_Y: r_max_y <= i_cfg_data;
                bso_pkg::CFG_RANK:  r_rank  <= i_cfg_data[bso_pkg::RANK_W-1:0];
                bso_pkg::CFG_COUNT: r_count <= i_cfg_data[bso_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient memories: load port and one registered read port
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            mem_x[i_coef_index] <= i_coef_x_val;
            mem_y[i_coef_index] <= i_coef_y_val;
        end
        r_rd_x <= mem_x[r_s];
        r_rd_y <= mem_y[r_s];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bso_pkg::ST_IDLE: begin
                if (eval_acc) begin
                    n_state = (chk_status == bso_pkg::STAT_OK) ? bso_pkg::ST_DIV
                                                               : bso_pkg::ST_FIN;
                end
            end
            bso_pkg::ST_DIV: begin
                if (div_x.done && div_y.done) begin
                    n_state = bso_pkg::ST_POW;
                end
            end
            bso_pkg::ST_POW: begin
                if (pow_last) begin
                    n_state = bso_pkg::ST_BASIS;
                end
            end
            bso_pkg::ST_BASIS: begin
                if (basis_last) begin
                    n_state = bso_pkg::ST_MAC;
                end
            end
            bso_pkg::ST_MAC: begin
                if (mac_done) begin
                    n_state = bso_pkg::ST_FIN;
                end
            end
            bso_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = bso_pkg::ST_IDLE;
                end
            end
            default: n_state = bso_pkg::ST_IDLE;
        endcase
    end

    // step strobes
    always_comb begin
        pow_last   = 1'b0;
        basis_last = 1'b0;
        mac_done   = 1'b0;
        unique case (r_state)
            bso_pkg::ST_POW:   pow_last   = (r_k == deg);
            bso_pkg::ST_BASIS: basis_last = r_ph && (r_i == deg);
            bso_pkg::ST_MAC:   mac_done   = !r_iss && !r_v1 && !r_v2;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bso_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // multipliers, each feeding a register
    assign q_x    = bso_pkg::Q_ONE - div_x.quot;
    assign q_y    = bso_pkg::Q_ONE - div_y.quot;
    assign m_pu_x = PW'(r_lu_x) * PW'(div_x.quot);
    assign m_pq_x = PW'(r_lq_x) * PW'(q_x);
    assign m_pu_y = PW'(r_lu_y) * PW'(div_y.quot);
    assign m_pq_y = PW'(r_lq_y) * PW'(q_y);
    assign m_b_x  = PW'(r_pu_x[r_i]) * PW'(r_pq_x[r_i]);
    assign m_b_y  = PW'(r_pu_y[r_i]) * PW'(r_pq_y[r_i]);
    assign m_w    = PW'(r_bx[r_i]) * PW'(r_by[r_j]);

    // datapath
    always_ff @(posedge i_clk) begin
        if (eval_acc) begin
            r_status <= chk_status;
        end

        // seed degree-zero powers
        if (r_state == bso_pkg::ST_DIV) begin
            r_lu_x         <= bso_pkg::Q_ONE;
            r_lq_x         <= bso_pkg::Q_ONE;
            r_lu_y         <= bso_pkg::Q_ONE;
            r_lq_y         <= bso_pkg::Q_ONE;
            r_pu_x[0]      <= bso_pkg::Q_ONE;
            r_pu_y[0]      <= bso_pkg::Q_ONE;
            r_pq_x[deg]    <= bso_pkg::Q_ONE;
            r_pq_y[deg]    <= bso_pkg::Q_ONE;
            r_k            <= IW'(1);
        end

        // one power of u and of 1-u per cycle
        if (r_state == bso_pkg::ST_POW) begin
            r_lu_x            <= m_pu_x[QW+29:30];
            r_lq_x            <= m_pq_x[QW+29:30];
            r_lu_y            <= m_pu_y[QW+29:30];
            r_lq_y            <= m_pq_y[QW+29:30];
            r_pu_x[r_k]       <= m_pu_x[QW+29:30];
            r_pu_y[r_k]       <= m_pu_y[QW+29:30];
            r_pq_x[deg - r_k] <= m_pq_x[QW+29:30];
            r_pq_y[deg - r_k] <= m_pq_y[QW+29:30];
            r_k               <= r_k + IW'(1);
            r_i               <= '0;
            r_ph              <= 1'b0;
        end

        // basis term: product then binomial weight
        if (r_state == bso_pkg::ST_BASIS) begin
            r_ph <= !r_ph;
            if (!r_ph) begin
                r_bp_x <= m_b_x[QW+29:30];
                r_bp_y <= m_b_y[QW+29:30];
            end else begin
                r_bx[r_i] <= QW'(r_bp_x * QW'(BINOM[deg][r_i]));
                r_by[r_i] <= QW'(r_bp_y * QW'(BINOM[deg][r_i]));
                r_i       <= basis_last ? '0 : r_i + IW'(1);
            end
            r_j     <= '0;
            r_s     <= '0;
            r_iss   <= 1'b1;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end

        // weight and memory read, then multiply, then accumulate
        if (r_state == bso_pkg::ST_MAC) begin
            r_v1 <= r_iss;
            r_v2 <= r_v1;
            if (r_iss) begin
                r_w <= m_w[QW+29:30];
                r_s <= r_s + AW'(1);
                if (r_j == deg) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                    if (r_i == deg) begin
                        r_iss <= 1'b0;
                    end
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            r_px_x <= $signed({1'b0, r_w}) * r_rd_x;
            r_px_y <= $signed({1'b0, r_w}) * r_rd_y;
            if (r_v2) begin
                r_acc_x <= r_acc_x + bso_pkg::ACC_W'(r_px_x);
                r_acc_y <= r_acc_y + bso_pkg::ACC_W'(r_px_y);
            end
        end

        // error results start from a zero sum
        if (eval_acc && chk_status != bso_pkg::STAT_OK) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end
    end

    // round half up to Q16.16, saturate
    function automatic logic signed [DW-1:0] finish(input logic signed [bso_pkg::ACC_W-1:0] acc);
        logic signed [bso_pkg::ACC_W-1:0] rnd;
        logic signed [bso_pkg::ACC_W-31:0] q;
        rnd = acc + bso_pkg::ACC_W'(64'sd536870912);
        q   = rnd[bso_pkg::ACC_W-1:30];
        if (q > bso_pkg::ACC_W'(64'sd2147483647)) begin
            finish = 32'sh7fff_ffff;
        end else if (q < -bso_pkg::ACC_W'(64'sd2147483648)) begin
            finish = 32'sh8000_0000;
        end else begin
            finish = q[DW-1:0];
        end
    endfunction

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == bso_pkg::ST_FIN && out_free) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bso_pkg::ST_FIN && out_free) begin
            r_o_x      <= finish(r_acc_x);
            r_o_y      <= finish(r_acc_y);
            r_o_status <= r_status;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_offset_x = r_o_x;
    assign o_offset_y = r_o_y;
    assign o_status   = r_o_status;

endmodule
